// File: hw/rtl/ols_homoskedastic_std_error_defines.svh
// assertion macros used by the rtl back end
`ifndef OLS_HOMOSKEDASTIC_STD_ERROR_DEFINES_SVH
`define OLS_HOMOSKEDASTIC_STD_ERROR_DEFINES_SVH
`ifndef SYNTHESIS
`define OLS_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define OLS_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define OLS_ASSERT_IMP(label, clk, rst, cond, prop)
`define OLS_ASSERT_NXT(label, clk, rst, cond, prop)
`endif
`endif

// File: hw/rtl/ols_se_pkg.sv
package ols_se_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] MODE_UNWEIGHTED = 2'd0;
  localparam logic [1:0] MODE_ANALYTIC   = 2'd1;
  localparam logic [1:0] MODE_FREQUENCY  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DENOM = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 10;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VARIANCE_MODE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODEL_TERMS   = 2'd1;

  localparam logic [15:0] WEIGHT_UNIT = 16'd256;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 96;
  localparam int QHI_STEPS   = 32;
  localparam int SQRT_STEPS  = 32;
  localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] sq;
    logic [15:0] w;
    logic [15:0] weight;
    logic [31:0] diag;
  } entry_t;

  typedef struct packed {
    logic [1:0] variance_mode;
    logic [9:0] model_terms;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } back_state_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_MUL_HI,
    RS_DIV,
    RS_SQRT,
    RS_DONE
  } root_state_t;

endpackage

// File: hw/rtl/ols_se_front.sv
module ols_se_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             opcode,
  input  logic signed [15:0]                     residual,
  input  logic [15:0]                            weight,
  input  logic [31:0]                            diag_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ols_se_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ols_se_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                   q_full,
  output logic                                   push,
  output ols_se_pkg::entry_t                     push_entry,
  output ols_se_pkg::cfg_t                       cfg
);

  logic        accept;
  logic [15:0] mag;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ols_se_pkg::REG_VARIANCE_MODE: cfg.variance_mode <= cfg_data[1:0];
        ols_se_pkg::REG_MODEL_TERMS:   cfg.model_terms   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mag = residual[15] ? (16'd0 - $unsigned(residual)) : $unsigned(residual);
    push_entry.sq     = mag * mag;
    push_entry.weight = weight;
    push_entry.diag   = diag_value;
    if (cfg.variance_mode inside {ols_se_pkg::MODE_ANALYTIC, ols_se_pkg::MODE_FREQUENCY}) begin
      push_entry.w = weight;
    end else begin
      push_entry.w = ols_se_pkg::WEIGHT_UNIT;
    end
    push_entry.cmd = ols_se_pkg::CMD_ADD;
    push           = 1'b0;
    if (accept) begin
      case (opcode)
        ols_se_pkg::OP_ADD: begin
          push = 1'b1;
        end
        ols_se_pkg::OP_QUERY: begin
          push           = 1'b1;
          push_entry.cmd = ols_se_pkg::CMD_QUERY;
        end
        ols_se_pkg::OP_CLEAR: begin
          push           = 1'b1;
          push_entry.cmd = ols_se_pkg::CMD_CLEAR;
        end
        default: push = 1'b0;
      endcase
    end
  end

endmodule

// File: hw/rtl/ols_se_queue.sv
module ols_se_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ols_se_pkg::entry_t push_entry,
  input  logic               pop,
  output ols_se_pkg::entry_t head,
  output logic               empty,
  output logic               full
);

  localparam int PTR_WIDTH = $clog2(ols_se_pkg::QUEUE_DEPTH);

  ols_se_pkg::entry_t   store [ols_se_pkg::QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0] wr_ptr;
  logic [PTR_WIDTH-1:0] rd_ptr;
  logic [PTR_WIDTH:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PTR_WIDTH + 1)'(ols_se_pkg::QUEUE_DEPTH));
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/ols_se_root.sv
module ols_se_root #(
  parameter int DENOM_WIDTH = 56
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            sum_sq,
  input  logic [31:0]            diag,
  input  logic [DENOM_WIDTH-1:0] denom,
  output logic                   done,
  output logic [31:0]            result
);

  localparam int SW = ols_se_pkg::STEP_WIDTH;

  ols_se_pkg::root_state_t state;
  ols_se_pkg::root_state_t state_next;

  logic [95:0]            prod;
  logic [31:0]            sum_hi;
  logic [31:0]            diag_r;
  logic [DENOM_WIDTH-1:0] dvs;
  logic [DENOM_WIDTH-1:0] rem;
  logic [63:0]            quo;
  logic                   ovf;
  logic [SW-1:0]          step;
  logic [63:0]            x;
  logic [63:0]            res;
  logic [63:0]            bitm;

  logic [DENOM_WIDTH:0]   trial;
  logic                   ge;
  logic [63:0]            root_sum;
  logic                   root_ge;
  logic                   div_last;
  logic                   sqrt_last;
  logic [63:0]            mul_lo;
  logic [63:0]            mul_hi;

  always_comb begin
    trial     = {rem, prod[95]};
    ge        = (trial >= {1'b0, dvs});
    root_sum  = res + bitm;
    root_ge   = (x >= root_sum);
    div_last  = (step == SW'(ols_se_pkg::DIV_STEPS - 1));
    sqrt_last = (step == SW'(ols_se_pkg::SQRT_STEPS - 1));
    mul_lo    = sum_sq[31:0] * diag;
    mul_hi    = sum_hi * diag_r;
  end

  always_comb begin
    state_next = state;
    case (state)
      ols_se_pkg::RS_IDLE:   if (start) state_next = ols_se_pkg::RS_MUL_HI;
      ols_se_pkg::RS_MUL_HI: state_next = ols_se_pkg::RS_DIV;
      ols_se_pkg::RS_DIV:    if (div_last) state_next = ols_se_pkg::RS_SQRT;
      ols_se_pkg::RS_SQRT:   if (sqrt_last) state_next = ols_se_pkg::RS_DONE;
      ols_se_pkg::RS_DONE:   state_next = ols_se_pkg::RS_IDLE;
      default:               state_next = ols_se_pkg::RS_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == ols_se_pkg::RS_DONE);
    result = ovf ? '1 : res[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ols_se_pkg::RS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ols_se_pkg::RS_IDLE: begin
        if (start) begin
          prod   <= {32'd0, mul_lo};
          sum_hi <= sum_sq[63:32];
          diag_r <= diag;
          dvs    <= denom;
          rem    <= '0;
          ovf    <= 1'b0;
          step   <= '0;
        end
      end
      ols_se_pkg::RS_MUL_HI: begin
        prod <= prod + {mul_hi, 32'd0};
      end
      ols_se_pkg::RS_DIV: begin
        prod <= {prod[94:0], 1'b0};
        rem  <= ge ? DENOM_WIDTH'(trial - {1'b0, dvs}) : trial[DENOM_WIDTH-1:0];
        quo  <= {quo[62:0], ge};
        ovf  <= ovf | (ge && (step < SW'(ols_se_pkg::QHI_STEPS)));
        if (div_last) begin
          x    <= {quo[62:0], ge};
          res  <= '0;
          bitm <= 64'h4000_0000_0000_0000;
          step <= '0;
        end else begin
          step <= step + 1'b1;
        end
      end
      ols_se_pkg::RS_SQRT: begin
        if (root_ge) begin
          x   <= x - root_sum;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ols_se_back.sv
`include "ols_homoskedastic_std_error_defines.svh"

module ols_se_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ols_se_pkg::cfg_t   cfg,
  input  ols_se_pkg::entry_t head,
  input  logic               q_empty,
  output logic               pop,
  output logic               done,
  output logic [31:0]        std_error,
  output logic [1:0]         status
);

  localparam int DW = (COUNT_WIDTH + 8 > 48) ? COUNT_WIDTH + 8 : 48;

  ols_se_pkg::back_state_t state;
  ols_se_pkg::back_state_t state_next;

  logic [63:0]            sum_sq;
  logic [47:0]            weight_sum;
  logic [COUNT_WIDTH-1:0] obs_count;
  logic                   saturated;

  logic [47:0]            term;
  logic [64:0]            sum_ext;
  logic [48:0]            wsum_ext;
  logic                   add_sat;
  logic [17:0]            k_w;
  logic [COUNT_WIDTH-1:0] terms_c;
  logic [COUNT_WIDTH-1:0] diff_c;
  logic                   positive;
  logic [DW-1:0]          denom;

  logic                   is_query;
  logic                   is_clear;
  logic                   denom_err;
  logic                   root_start;
  logic                   quick;
  logic                   root_done;
  logic [31:0]            root_result;

  always_comb begin
    term     = {16'd0, head.sq} * {32'd0, head.w};
    sum_ext  = {1'b0, sum_sq} + {17'd0, term};
    wsum_ext = {1'b0, weight_sum} + {33'd0, head.weight};
    add_sat  = sum_ext[64] || wsum_ext[48] || (obs_count == '1);
    k_w      = {cfg.model_terms, 8'd0};
    terms_c  = COUNT_WIDTH'(cfg.model_terms);
    diff_c   = obs_count - terms_c;
    if (cfg.variance_mode == ols_se_pkg::MODE_FREQUENCY) begin
      positive = (weight_sum > {30'd0, k_w});
      denom    = DW'(weight_sum - {30'd0, k_w});
    end else begin
      positive = (obs_count > terms_c);
      denom    = DW'({diff_c, 8'd0});
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ols_se_pkg::ST_IDLE: if (root_start) state_next = ols_se_pkg::ST_WAIT;
      ols_se_pkg::ST_WAIT: if (root_done) state_next = ols_se_pkg::ST_IDLE;
      default:             state_next = ols_se_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == ols_se_pkg::ST_IDLE) && !q_empty;
    is_query   = pop && (head.cmd == ols_se_pkg::CMD_QUERY);
    is_clear   = pop && (head.cmd == ols_se_pkg::CMD_CLEAR);
    root_start = is_query && positive;
    quick      = is_query && !positive;
    denom_err  = done && (status == ols_se_pkg::STATUS_DENOM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ols_se_pkg::ST_IDLE;
      sum_sq     <= '0;
      weight_sum <= '0;
      obs_count  <= '0;
      saturated  <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= quick || ((state == ols_se_pkg::ST_WAIT) && root_done);
      if (pop) begin
        case (head.cmd)
          ols_se_pkg::CMD_ADD: begin
            sum_sq     <= sum_ext[64] ? '1 : sum_ext[63:0];
            weight_sum <= wsum_ext[48] ? '1 : wsum_ext[47:0];
            if (obs_count != '1) begin
              obs_count <= obs_count + 1'b1;
            end
            if (add_sat) begin
              saturated <= 1'b1;
            end
          end
          ols_se_pkg::CMD_CLEAR: begin
            sum_sq     <= '0;
            weight_sum <= '0;
            obs_count  <= '0;
            saturated  <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quick) begin
      std_error <= '0;
      status    <= ols_se_pkg::STATUS_DENOM;
    end else if ((state == ols_se_pkg::ST_WAIT) && root_done) begin
      std_error <= root_result;
      status    <= saturated ? ols_se_pkg::STATUS_SAT : ols_se_pkg::STATUS_OK;
    end
  end

  ols_se_root #(
    .DENOM_WIDTH(DW)
  ) u_root (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .sum_sq (sum_sq),
    .diag   (head.diag),
    .denom  (denom),
    .done   (root_done),
    .result (root_result)
  );

  `OLS_ASSERT_IMP(a_root_denom_nonzero, clk, rst, root_start, denom != '0)
  `OLS_ASSERT_NXT(a_clear_empties, clk, rst, is_clear, obs_count == '0 && !saturated)
  `OLS_ASSERT_IMP(a_denom_err_zero, clk, rst, denom_err, std_error == '0)
  `OLS_ASSERT_IMP(a_root_done_waiting, clk, rst, root_done, state == ols_se_pkg::ST_WAIT)

endmodule

// File: hw/rtl/ols_homoskedastic_std_error.sv
// channel   direction  handshake                 payload
// command   in         start, busy               opcode, residual, weight, diag_value
// result    out        done                      std_error, status
// config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// add and clear items retire once they reach the head of the queue and no query is running
// a query with a positive denominator runs through two 32x32 partial products,
// a 96-step bit-serial divider and a 32-step bit-pair square root
// a query with a non-positive denominator answers in the cycle after it leaves the queue
// busy is high while the two-entry queue is full; results cannot be held off
// synchronous reset clears config, accumulators and the queue
module ols_homoskedastic_std_error #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             opcode,
  input  logic signed [15:0]                     residual,
  input  logic [15:0]                            weight,
  input  logic [31:0]                            diag_value,
  output logic                                   done,
  output logic [31:0]                            std_error,
  output logic [1:0]                             status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ols_se_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ols_se_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  ols_se_pkg::entry_t push_entry;
  ols_se_pkg::entry_t head;
  ols_se_pkg::cfg_t   cfg;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;

  ols_se_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .residual   (residual),
    .weight     (weight),
    .diag_value (diag_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry),
    .cfg        (cfg)
  );

  ols_se_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  ols_se_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .done      (done),
    .std_error (std_error),
    .status    (status)
  );

endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = 16;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 112;
  localparam int LARGE_ADDS = 24;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [ols_se_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [31:0] se;
    logic [1:0]  st;
  } se_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = '0;
  logic signed [15:0] residual = '0;
  logic [15:0] weight = '0;
  logic [31:0] diag_value = '0;
  logic done;
  logic [31:0] std_error;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ols_se_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [ols_se_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // accumulator and register copies
  logic [63:0] acc_sumsq = '0;
  logic [47:0] acc_wsum = '0;
  logic [CNT_W-1:0] acc_count = '0;
  logic acc_sat = 1'b0;
  logic [1:0] cfg_mode = '0;
  logic [9:0] cfg_terms = '0;

  se_answer_t answers_due[$];
  se_answer_t head;
  bit failed = 1'b0;

  ols_homoskedastic_std_error #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .residual(residual),
    .weight(weight),
    .diag_value(diag_value),
    .done(done),
    .std_error(std_error),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // floor(sqrt(s * v / d)), clipped to 32 bits
  function automatic logic [31:0] root_of_quotient(logic [63:0] s, logic [31:0] v,
                                                   logic [56:0] d);
    logic [127:0] quot;
    logic [63:0] root;
    logic [63:0] cand;
    quot = {64'd0, s} * {96'd0, v};
    quot = quot / {71'd0, d};
    if (quot[127:64] != '0) return 32'hFFFF_FFFF;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= quot[63:0]) root = cand;
    end
    return root[31:0];
  endfunction

  function automatic void account_item(logic [1:0] op, logic [15:0] res_bits,
                                       logic [15:0] w_in, logic [31:0] diag);
    logic [15:0] mag;
    logic [15:0] w_eff;
    logic [64:0] sum_next;
    logic [48:0] wsum_next;
    logic [56:0] denom;
    bit positive;
    se_answer_t ans;
    case (op)
      ols_se_pkg::OP_ADD: begin
        mag = res_bits[15] ? 16'(-res_bits) : res_bits;
        w_eff = (cfg_mode == ols_se_pkg::MODE_ANALYTIC ||
                 cfg_mode == ols_se_pkg::MODE_FREQUENCY) ? w_in : ols_se_pkg::WEIGHT_UNIT;
        sum_next = {1'b0, acc_sumsq} + 65'(mag) * 65'(mag) * 65'(w_eff);
        if (sum_next[64]) begin
          acc_sumsq = '1;
          acc_sat = 1'b1;
        end else begin
          acc_sumsq = sum_next[63:0];
        end
        wsum_next = {1'b0, acc_wsum} + 49'(w_in);
        if (wsum_next[48]) begin
          acc_wsum = '1;
          acc_sat = 1'b1;
        end else begin
          acc_wsum = wsum_next[47:0];
        end
        if (acc_count == '1) begin
          acc_sat = 1'b1;
        end else begin
          acc_count = acc_count + 1'b1;
        end
      end
      ols_se_pkg::OP_QUERY: begin
        if (cfg_mode == ols_se_pkg::MODE_FREQUENCY) begin
          positive = acc_wsum > (48'(cfg_terms) << 8);
          denom = 57'(acc_wsum - (48'(cfg_terms) << 8));
        end else begin
          positive = acc_count > cfg_terms;
          denom = 57'(acc_count - cfg_terms) << 8;
        end
        if (!positive) begin
          ans.se = '0;
          ans.st = ols_se_pkg::STATUS_DENOM;
        end else begin
          ans.se = root_of_quotient(acc_sumsq, diag, denom);
          ans.st = acc_sat ? ols_se_pkg::STATUS_SAT : ols_se_pkg::STATUS_OK;
        end
        answers_due.push_back(ans);
      end
      ols_se_pkg::OP_CLEAR: begin
        acc_sumsq = '0;
        acc_wsum = '0;
        acc_count = '0;
        acc_sat = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [15:0] rand_residual();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_diag();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_gap(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [15:0] res_bits,
                           input logic [15:0] w_in, input logic [31:0] diag,
                           input int unsigned gap);
    start <= 1'b1;
    opcode <= op;
    residual <= res_bits;
    weight <= w_in;
    diag_value <= diag;
    do @(posedge clk); while (busy !== 1'b0);
    account_item(op, res_bits, w_in, diag);
    idle_gap(gap);
  endtask

  // wait for outstanding answers plus the tail of any add or clear
  task automatic settle();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ols_se_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [ols_se_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == ols_se_pkg::REG_VARIANCE_MODE) cfg_mode = data[1:0];
    else if (idx == ols_se_pkg::REG_MODEL_TERMS) cfg_terms = data;
  endtask

  task automatic configure(input logic [9:0] mode_data, input logic [9:0] terms_data,
                           input bit poke_spare);
    settle();
    if (poke_spare) write_reg(REG_SPARE, 10'($urandom));
    write_reg(ols_se_pkg::REG_VARIANCE_MODE, mode_data);
    write_reg(ols_se_pkg::REG_MODEL_TERMS, terms_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_query();
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
  endtask

  task automatic test_opcodes();
    send_item(ols_se_pkg::OP_ADD, 16'h7FFF, 16'h0000, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_ADD, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF, pick_gap());
    send_item(ols_se_pkg::OP_ADD, 16'h0000, 16'h5A5A, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_ADD, 16'hFFFF, 16'h0001, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
    send_item(OP_RESERVED, 16'hA5A5, 16'h5A5A, 32'hDEAD_BEEF, pick_gap());
    send_item(ols_se_pkg::OP_CLEAR, 16'h1234, 16'h4321, 32'h0000_0001, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
  endtask

  task automatic test_weighted_modes();
    configure({8'd0, ols_se_pkg::MODE_ANALYTIC}, 10'd0, 1'b1);
    send_item(ols_se_pkg::OP_ADD, 16'h8000, 16'hFFFF, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_ADD, 16'h7FFF, 16'h0000, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_ADD, 16'h0100, 16'h0100, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'hFFFF_FFFF, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0000_0001, pick_gap());
    // weight sum grows in every mode
    configure({8'd0, ols_se_pkg::MODE_FREQUENCY}, 10'd1, 1'b0);
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
    configure({8'd0, ols_se_pkg::MODE_FREQUENCY}, 10'h3FF, 1'b0);
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
    // unused mode, with upper data bits set
    configure({8'hFF, MODE_SPARE}, 10'd2, 1'b0);
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0003_0000, pick_gap());
    send_item(ols_se_pkg::OP_ADD, 16'h0180, 16'hFFFF, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0000_8000, pick_gap());
    configure({8'h00, MODE_SPARE}, 10'd4, 1'b0);
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
  endtask

  task automatic test_random_phases();
    int unsigned sent;
    int unsigned r;
    logic [1:0] mode;
    logic [9:0] terms;
    bit burst;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = 2'($urandom);
      if ($urandom_range(0, 3) == 0) terms = 10'($urandom);
      else terms = 10'($urandom_range(0, 8));
      if (phase == 0) terms = '0;
      if (phase == 1) begin
        mode = ols_se_pkg::MODE_FREQUENCY;
        terms = '1;
      end
      configure({phase[0] ? 8'($urandom) : 8'd0, mode}, terms, phase == 5);
      burst = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 73) begin
          send_item(ols_se_pkg::OP_ADD, rand_residual(), rand_weight(), rand_diag(), 0);
        end else if (r < 95) begin
          send_item(ols_se_pkg::OP_QUERY, rand_residual(), rand_weight(), rand_diag(), 0);
        end else if (r < 97) begin
          send_item(ols_se_pkg::OP_CLEAR, rand_residual(), rand_weight(), rand_diag(), 0);
        end else begin
          send_item(OP_RESERVED, rand_residual(), rand_weight(), rand_diag(), 0);
        end
        if (r < 97) sent++;
        idle_gap(burst ? 0 : pick_gap());
      end
    end
  endtask

  task automatic test_large_values();
    configure({8'd0, ols_se_pkg::MODE_ANALYTIC}, 10'd0, 1'b0);
    send_item(ols_se_pkg::OP_CLEAR, 16'h0000, 16'h0000, 32'h0000_0000, 0);
    // largest terms, the scaled quotient leaves 64 bits for a full diagonal
    for (int n = 0; n < LARGE_ADDS; n++) begin
      send_item(ols_se_pkg::OP_ADD, 16'h8000, 16'hFFFF, rand_diag(), 0);
      if (n == LARGE_ADDS / 2) begin
        send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, rand_diag(), 0);
      end
    end
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'hFFFF_FFFF, pick_gap());
    configure({8'd0, ols_se_pkg::MODE_FREQUENCY}, 10'h3FF, 1'b0);
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0000_0001, pick_gap());
    send_item(ols_se_pkg::OP_CLEAR, 16'h0000, 16'h0000, 32'h0000_0000, pick_gap());
    send_item(ols_se_pkg::OP_QUERY, 16'h0000, 16'h0000, 32'h0001_0000, pick_gap());
  endtask

  task automatic finish_run();
    settle();
    if (!failed) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result std_error %h status %0d", $time, std_error, status);
        failed = 1'b1;
      end else begin
        head = answers_due.pop_front();
        if (std_error !== head.se) begin
          $display("%0t: std_error expected %h actual %h", $time, head.se, std_error);
          failed = 1'b1;
        end
        if (status !== head.st) begin
          $display("%0t: status expected %0d actual %0d", $time, head.st, status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_query();
    test_opcodes();
    test_weighted_modes();
    test_random_phases();
    test_large_values();
    finish_run();
  end

  initial begin
    #30_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
